[design/ordered_array_list_insert_search_defines.svh]
// Assertion macros for the design file that checks its own logic.
`ifndef ORDERED_ARRAY_LIST_INSERT_SEARCH_DEFINES_SVH
`define ORDERED_ARRAY_LIST_INSERT_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OALIS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oalis assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OALIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oalis assertion failed");

`endif

[design/oalis_pkg.sv]
package oalis_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    // Request codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

endpackage

[design/ordered_array_list_insert_search.sv]
// Ordered array list with positional insert and linear search. The block keeps up to
// CAPACITY (64) signed 32-bit keys in slots 0 to count-1 of a single-port-write,
// single-port-read memory, plus the element count. An insert beat places its key at the
// given position after moving every later entry up one slot, one entry per cycle. A refused
// insert (list full or position beyond the count) moves nothing and goes straight to the
// result. A search beat reads one slot per cycle from the head and stops at the first
// match, or reports a miss after the last slot, or without reading any slot on an empty
// list. The memory's one read port and one write port set this pace.
// Input beats are taken only while the sequencer is idle; the result register sits apart,
// so a new request can be accepted while the previous result still waits for its
// consumer. Reset empties the list; the memory itself is not cleared, since only slots
// below the count are ever read.
`include "ordered_array_list_insert_search_defines.svh"

module ordered_array_list_insert_search
    import oalis_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Request channel.
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_req_type,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [CNT_W-1:0]        i_position,
    // Result channel.
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_accepted,
    output logic                    o_found,
    output logic [IDX_W-1:0]        o_found_position,
    output logic [CNT_W-1:0]        o_element_count
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_PLACE  = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]              r_state;
    logic [2:0]              n_state;

    // The request being worked on.
    logic signed [KEY_W-1:0] r_key;
    logic [CNT_W-1:0]        r_pos;

    // List state.
    logic [CNT_W-1:0]        r_count;

    // Scan pointer: the destination slot while shifting, the slot to read while searching.
    logic [CNT_W-1:0]        r_ptr;
    logic [CNT_W-1:0]        ptr_m1;

    // Pending shift write: the slot that takes the entry read in the previous cycle.
    logic                    r_wv;
    logic [IDX_W-1:0]        r_wa;

    // Pending compare: the read data of the previous cycle belongs to slot r_ca.
    logic                    r_cv;
    logic [IDX_W-1:0]        r_ca;

    // Result waiting for the output register.
    logic                    r_acc;
    logic                    r_fnd;
    logic [IDX_W-1:0]        r_fpos;

    // Output register.
    logic                    r_out_valid;
    logic                    r_o_acc;
    logic                    r_o_fnd;
    logic [IDX_W-1:0]        r_o_fpos;
    logic [CNT_W-1:0]        r_o_cnt;

    // Entry memory.
    logic signed [KEY_W-1:0] mem_q [CAPACITY];
    logic signed [KEY_W-1:0] r_rdata;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [KEY_W-1:0] wr_data;

    logic                    in_beat;
    logic                    refused;
    logic                    issue_shift;
    logic                    hit;
    logic                    issue_search;
    logic                    search_miss;
    logic                    resp_load;

    assign in_beat  = i_in_valid && o_in_ready;
    assign refused  = (r_count >= CNT_W'(CAPACITY)) || (i_position > r_count);
    assign ptr_m1   = r_ptr - CNT_W'(1);

    // Shifting walks the destination pointer down to the insert position.
    assign issue_shift  = (r_state == S_SHIFT) && (r_ptr > r_pos);
    // A match on the previous read ends the search before another read is issued.
    assign hit          = (r_state == S_SEARCH) && r_cv && (r_rdata == r_key);
    assign issue_search = (r_state == S_SEARCH) && !hit && (r_ptr < r_count);
    assign search_miss  = (r_state == S_SEARCH) && !hit && !issue_search && !r_cv;
    assign resp_load    = (r_state == S_RESP) && (!r_out_valid || i_out_ready);

    assign rd_addr = (r_state == S_SHIFT) ? ptr_m1[IDX_W-1:0] : r_ptr[IDX_W-1:0];

    // The write port serves the pending shift write, or the new key once shifting is over.
    assign wr_en   = r_wv || (r_state == S_PLACE);
    assign wr_addr = r_wv ? r_wa : r_pos[IDX_W-1:0];
    assign wr_data = r_wv ? r_rdata : r_key;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= wr_data;
        end
        r_rdata <= mem_q[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (i_req_type == REQ_SEARCH) begin
                        n_state = S_SEARCH;
                    end else if (refused) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (!issue_shift) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                n_state = S_RESP;
            end
            S_SEARCH: begin
                if (hit || search_miss) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (resp_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wv        <= 1'b0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wv    <= issue_shift;
            r_cv    <= issue_search;
            if (r_state == S_PLACE) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (resp_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_key  <= i_key;
            r_pos  <= i_position;
            r_fnd  <= 1'b0;
            r_fpos <= '0;
            if (i_req_type == REQ_SEARCH) begin
                r_ptr <= '0;
                r_acc <= 1'b0;
            end else begin
                r_ptr <= r_count;
                r_acc <= !refused;
            end
        end else if (issue_shift) begin
            r_ptr <= ptr_m1;
        end else if (issue_search) begin
            r_ptr <= r_ptr + CNT_W'(1);
        end
        if (issue_shift) begin
            r_wa <= r_ptr[IDX_W-1:0];
        end
        if (issue_search) begin
            r_ca <= r_ptr[IDX_W-1:0];
        end
        if (hit) begin
            r_fnd  <= 1'b1;
            r_fpos <= r_ca;
        end
        if (resp_load) begin
            r_o_acc  <= r_acc;
            r_o_fnd  <= r_fnd;
            r_o_fpos <= r_fpos;
            r_o_cnt  <= r_count;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_o_acc;
    assign o_found          = r_o_fnd;
    assign o_found_position = r_o_fpos;
    assign o_element_count  = r_o_cnt;

    // The count never grows past the capacity.
    `OALIS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    // A shift write never lands on the slot being read in the same cycle.
    `OALIS_ASSERT_SAME(a_shift_no_clash, i_clk, i_rst_n, r_wv && issue_shift,
        r_wa != rd_addr)
    // Placing the key grows the list by exactly one.
    `OALIS_ASSERT_NEXT(a_place_count, i_clk, i_rst_n, r_state == S_PLACE,
        r_count == $past(r_count) + CNT_W'(1))

endmodule
